// File: hw/rtl/fchr_pkg.sv
// Shared types, constants and lookup functions for the fault code handshake responder.
`default_nettype none

package fchr_pkg;

   localparam int WIN_W   = 32;
   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 12;
   localparam int IDX_W   = 2;

   localparam logic       KIND_ANSWER = 1'b0;
   localparam logic       KIND_FAULT  = 1'b1;
   localparam logic [IDX_W-1:0] LAST_SYNC_IDX = 2'd3;
   localparam logic [BYTE_W-1:0] SHORT_ANSWER_HI = 8'h01;
   localparam logic [BYTE_W-1:0] SHORT_ANSWER_LO = 8'hb0;

   typedef enum logic [1:0] {
      PH_FULL  = 2'd0,
      PH_SHORT = 2'd1,
      PH_FAULT = 2'd2
   } phase_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] tx_byte;
      logic [CODE_W-1:0] fault_code;
      logic              last;
   } result_type;

   // Up to two results produced by one request.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } pair_type;

   // Newest byte of each sync word; the three older bytes are zero.
   function automatic logic [BYTE_W-1:0] sync_byte(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         2'd0:    val = 8'ha0;
         2'd1:    val = 8'hb1;
         2'd2:    val = 8'h82;
         default: val = 8'h93;
      endcase
      return val;
   endfunction

   function automatic logic [BYTE_W-1:0] answer_hi(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         2'd0:    val = 8'h01;
         2'd1:    val = 8'hff;
         2'd2:    val = 8'h26;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [BYTE_W-1:0] answer_lo(input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         2'd0:    val = 8'hb0;
         2'd1:    val = 8'h5f;
         2'd2:    val = 8'ha4;
         default: val = 8'ha0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fchr_in_reg.sv
// Request input register: holds one received byte until the engine takes it.
`default_nettype none

module fchr_in_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [fchr_pkg::BYTE_W-1:0] req_rx_byte,
   input  wire logic                      buf_ready,
   output logic                           in_valid,
   output logic [fchr_pkg::BYTE_W-1:0]    in_byte
);
   import fchr_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   assign req_stall = valid_ff & ~buf_ready;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (buf_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fchr_engine.sv
// Handshake state and result logic: byte window, phase, sync index, fault byte count.
`default_nettype none

module fchr_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire logic [fchr_pkg::BYTE_W-1:0] in_byte,
   output fchr_pkg::pair_type               pair
);
   import fchr_pkg::*;

   logic [WIN_W-1:0]  win_ff, win_in;
   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              cnt_ff, cnt_in;
   logic              match;
   logic [BYTE_W-1:0] prev;

   always_comb begin
      win_in   = {win_ff[WIN_W-BYTE_W-1:0], in_byte};
      prev     = win_ff[BYTE_W-1:0];
      match    = (win_in == {{(WIN_W-BYTE_W){1'b0}}, sync_byte(idx_ff)});
      phase_in = phase_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      pair     = '0;
      case (phase_ff)
         PH_SHORT: begin
            if (match) begin
               idx_in   = idx_ff + 2'd1;
               phase_in = PH_FAULT;
               pair.count          = 2'd2;
               pair.first.kind     = KIND_ANSWER;
               pair.first.tx_byte  = SHORT_ANSWER_HI;
               pair.second.kind    = KIND_ANSWER;
               pair.second.tx_byte = SHORT_ANSWER_LO;
               pair.second.last    = 1'b1;
            end
         end
         PH_FAULT: begin
            if (!cnt_ff) begin
               cnt_in = 1'b1;
            end else begin
               cnt_in   = 1'b0;
               phase_in = PH_FULL;
               pair.count            = 2'd1;
               pair.first.kind       = KIND_FAULT;
               pair.first.fault_code = {in_byte[3:0], prev};
               pair.first.last       = 1'b1;
            end
         end
         default: begin
            // full sync; unused phase code behaves the same
            if (match) begin
               pair.count          = 2'd2;
               pair.first.kind     = KIND_ANSWER;
               pair.first.tx_byte  = answer_hi(idx_ff);
               pair.second.kind    = KIND_ANSWER;
               pair.second.tx_byte = answer_lo(idx_ff);
               pair.second.last    = 1'b1;
               if (idx_ff == LAST_SYNC_IDX) begin
                  idx_in   = '0;
                  phase_in = PH_SHORT;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         phase_ff <= PH_FULL;
         idx_ff   <= '0;
         cnt_ff   <= 1'b0;
      end else if (fire) begin
         win_ff   <= win_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_cnt_only_in_fault: assert property (@(posedge clock) disable iff (reset)
      cnt_ff |-> phase_ff == PH_FAULT)
      else $error("fault byte count set outside fault read phase");

   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      (fire && pair.count == 2'd2) |->
         (pair.first.kind == KIND_ANSWER && pair.second.kind == KIND_ANSWER &&
          !pair.first.last && pair.second.last))
      else $error("answer pair malformed");

   a_short_to_fault: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_ff == PH_SHORT && pair.count != 2'd0) |=> phase_ff == PH_FAULT)
      else $error("short sync match did not enter fault read phase");

endmodule

`default_nettype wire

// File: hw/rtl/fchr_out_buf.sv
// Two-entry result register: presents results in order and frees up for the next request.
`default_nettype none

module fchr_out_buf (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire fchr_pkg::pair_type          pair,
   output logic                             buf_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_kind,
   output logic [fchr_pkg::BYTE_W-1:0]      rsp_tx_byte,
   output logic [fchr_pkg::CODE_W-1:0]      rsp_fault_code,
   output logic                             rsp_last
);
   import fchr_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   result_type e0_ff, e0_in;
   result_type e1_ff, e1_in;
   logic       pop;

   assign pop       = (cnt_ff != 2'd0) & ~rsp_stall;
   // room for a new pair once at most the head remains and it leaves now
   assign buf_ready = (cnt_ff == 2'd0) | ((cnt_ff == 2'd1) & ~rsp_stall);

   always_comb begin
      cnt_in = cnt_ff;
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            e0_in  = e1_ff;
            cnt_in = 2'd1;
         end else begin
            cnt_in = 2'd0;
         end
      end
      if (load) begin
         case (pair.count)
            2'd2: begin
               e0_in  = pair.first;
               e1_in  = pair.second;
               cnt_in = 2'd2;
            end
            2'd1: begin
               e0_in  = pair.first;
               cnt_in = 2'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_kind       = e0_ff.kind;
   assign rsp_tx_byte    = e0_ff.tx_byte;
   assign rsp_fault_code = e0_ff.fault_code;
   assign rsp_last       = e0_ff.last;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result count out of range");

   a_full_order: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (!e0_ff.last && e1_ff.last))
      else $error("held pair out of order");

   a_drain_second: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !rsp_stall) |=> cnt_ff == 2'd1)
      else $error("second result lost or overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/fault_code_handshake_responder.sv
// Fault code handshake responder top level: input register, engine and result register.
//
// Request channel (req_): one received serial byte per request, valid/stall handshake.
// Response channel (rsp_): answer bytes (kind 0) and fault code reports (kind 1);
// rsp_last marks the final response caused by a request.
// A request is registered in the input register; once the result register has room,
// the engine updates its state and loads its responses into the result register,
// whose head entry drives the rsp_ ports until it is taken.
// Throughput: one request per cycle while rsp_stall is low, when it causes no response
// or one fault report; a request that causes a two-byte answer fills both result
// register entries, so the next request waits until only the second byte is left.
// When rsp_stall is high the response is held; once the result register cannot take
// the next pair, the input register holds its byte and req_stall rises.
// Synchronous reset clears the byte window, enters the full sync phase with sync
// index zero and empties both registers; requests are taken the cycle after reset.
`default_nettype none

module fault_code_handshake_responder (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [fchr_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_kind,
   output logic [fchr_pkg::BYTE_W-1:0]      rsp_tx_byte,
   output logic [fchr_pkg::CODE_W-1:0]      rsp_fault_code,
   output logic                             rsp_last
);
   import fchr_pkg::*;

   logic              buf_ready;
   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;
   logic              fire;
   pair_type          pair;

   assign fire = in_valid & buf_ready;

   fchr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .buf_ready   (buf_ready),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   fchr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (in_byte),
      .pair    (pair)
   );

   fchr_out_buf u_out_buf (
      .clock          (clock),
      .reset          (reset),
      .load           (fire),
      .pair           (pair),
      .buf_ready      (buf_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_fault_code (rsp_fault_code),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
